// ----- design/tlcd_pkg.sv -----
// Package for the timer / LCD line / interrupt unit.
// Holds register indexes, item kinds, timing constants and start addresses.
// No dependencies.
package tlcd_pkg;

    localparam int TLCD_COUNT_WIDTH = 32;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam int S_TDATA_W = 40;  // instr_count(32) + master_enable(1), padded
    localparam int M_TDATA_W = 48;  // 41 result bits, padded

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TIMER_CONTROL    = 3'd0,
        REG_TIMER_RELOAD     = 3'd1,
        REG_LINE_COMPARE     = 3'd2,
        REG_STAT_ENABLES     = 3'd3,
        REG_INTERRUPT_ENABLE = 3'd4
    } cfg_reg_t;

    // Item kinds carried in tuser
    typedef enum logic {
        REQ_UPDATE   = 1'b0,
        REQ_DISPATCH = 1'b1
    } req_t;

    // LCD modes
    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_OAM      = 2'd2,
        MODE_TRANSFER = 2'd3
    } lcd_mode_t;

    localparam logic [7:0] LINE_PERIOD  = 8'd114;
    localparam logic [7:0] LAST_LINE    = 8'd152;   // line count 153, wraps after this
    localparam logic [7:0] VBLANK_LINE  = 8'd144;
    localparam logic [7:0] OAM_END      = 8'd20;
    localparam logic [7:0] TRANSFER_END = 8'd63;

    localparam logic [6:0] VEC_NONE   = 7'h00;
    localparam logic [6:0] VEC_VBLANK = 7'h40;
    localparam logic [6:0] VEC_STAT   = 7'h48;
    localparam logic [6:0] VEC_TIMER  = 7'h50;

    // Request flag bit positions
    localparam int FLAG_VBLANK = 0;
    localparam int FLAG_STAT   = 1;
    localparam int FLAG_TIMER  = 2;
    localparam int FLAG_SERIAL = 3;
    localparam int FLAG_JOYPAD = 4;

    // Timer and divider period for a period select code
    function automatic logic [8:0] period_of(input logic [1:0] sel);
        logic [8:0] p;
        case (sel)
            2'd0:    p = 9'd256;
            2'd1:    p = 9'd4;
            2'd2:    p = 9'd16;
            2'd3:    p = 9'd64;
            default: p = 9'd256;
        endcase
        return p;
    endfunction

endpackage

// ----- design/timer_lcd_interrupt_unit.sv -----
// Top level of the timer / LCD line / interrupt unit.
// Depends on tlcd_pkg.
//
// Channel   Dir  Handshake         Contents
// s_*       in   tvalid/tready     tuser: req_type; tdata: instr_count, master_enable
// m_*       out  tvalid/tready     tdata: vector .. render_line, one result per item
// cfg_*     in   cfg_wr_en only    cfg_index selects register, cfg_wdata value
//
// Each item passes from input transfer to result through the input register,
// then through the state update into the result register.
// One item per cycle while m_* does not stall; bound by the single state update per cycle.
// rst_n clears all counters, marks, flags, configuration and both valid bits.
// A stall on m_* holds the result register; the input register still takes
// one more item, then s_tready drops until the result is taken.
module timer_lcd_interrupt_unit
    import tlcd_pkg::*;
#(
    parameter int COUNT_WIDTH = TLCD_COUNT_WIDTH
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [31:0] instr_count, [32] master_enable, [39:33] zero
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // [0] req_type
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [6:0] vector, [7] clear_master, [15:8] timer_value, [23:16] divider_value,
    // [31:24] line_value, [33:32] lcd_mode, [34] coincidence,
    // [39:35] pending_flags, [40] render_line, [47:41] zero
    output logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    // Configuration registers
    logic [2:0] timer_control_reg;
    logic [7:0] timer_reload_reg;
    logic [7:0] line_compare_reg;
    logic [3:0] stat_enables_reg;
    logic [4:0] interrupt_enable_reg;

    // Input register
    logic                   in_valid_reg;
    req_t                   in_type_reg;
    logic [COUNT_WIDTH-1:0] in_count_reg;
    logic                   in_me_reg;

    // Architectural state
    logic [COUNT_WIDTH-1:0] timer_mark_reg, timer_mark_next;
    logic [COUNT_WIDTH-1:0] divider_mark_reg, divider_mark_next;
    logic [COUNT_WIDTH-1:0] line_mark_reg, line_mark_next;
    logic [7:0]             timer_reg, timer_next;
    logic [7:0]             divider_reg, divider_next;
    logic [7:0]             line_reg, line_next;
    lcd_mode_t              mode_reg, mode_next;
    logic                   coin_reg, coin_next;
    logic [4:0]             flags_reg, flags_next;

    // Result register
    logic                   out_valid_reg;
    logic [M_TDATA_W-1:0]   out_data_reg, out_data_next;

    logic out_ready;
    logic fire;

    // Result register is free when empty or being drained this cycle
    assign out_ready = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_control_reg    <= '0;
            timer_reload_reg     <= '0;
            line_compare_reg     <= '0;
            stat_enables_reg     <= '0;
            interrupt_enable_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TIMER_CONTROL:    timer_control_reg    <= cfg_wdata[2:0];
                REG_TIMER_RELOAD:     timer_reload_reg     <= cfg_wdata;
                REG_LINE_COMPARE:     line_compare_reg     <= cfg_wdata;
                REG_STAT_ENABLES:     stat_enables_reg     <= cfg_wdata[3:0];
                REG_INTERRUPT_ENABLE: interrupt_enable_reg <= cfg_wdata[4:0];
                default:              ;  // drop writes beyond the register list
            endcase
        end
    end

    // Input register: take a transfer whenever the slot is free or drains now
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_type_reg  <= req_t'(s_tuser);
            in_count_reg <= COUNT_WIDTH'(s_tdata[31:0]);
            in_me_reg    <= s_tdata[32];
        end
    end

    // One item's full update, written in the order the counters are visited
    always_comb
    begin
        logic [COUNT_WIDTH-1:0] tdiff, ddiff, ldiff, elapsed, period_w;
        logic                   tpast, dpast, lpast;
        logic [4:0]             active;
        logic [6:0]             vec;
        logic                   clr, render;

        timer_mark_next   = timer_mark_reg;
        divider_mark_next = divider_mark_reg;
        line_mark_next    = line_mark_reg;
        timer_next        = timer_reg;
        divider_next      = divider_reg;
        line_next         = line_reg;
        mode_next         = mode_reg;
        coin_next         = coin_reg;
        flags_next        = flags_reg;
        vec               = VEC_NONE;
        clr               = 1'b0;
        render            = 1'b0;
        active            = interrupt_enable_reg & flags_reg;

        period_w = COUNT_WIDTH'(period_of(timer_control_reg[1:0]));
        tdiff    = in_count_reg - timer_mark_reg;
        ddiff    = in_count_reg - divider_mark_reg;
        ldiff    = in_count_reg - line_mark_reg;
        // Advance only when count is strictly beyond mark + period, no wrap
        tpast    = (in_count_reg > timer_mark_reg) && (tdiff > period_w);
        dpast    = (in_count_reg > divider_mark_reg) && (ddiff > period_w);
        lpast    = (in_count_reg > line_mark_reg) && (ldiff > COUNT_WIDTH'(LINE_PERIOD));
        elapsed  = ldiff;

        if (in_type_reg == REQ_UPDATE)
        begin
            if (tpast)
            begin
                timer_mark_next = in_count_reg;
                if (timer_control_reg[2])
                begin
                    if (timer_reg == 8'hFF)
                    begin
                        // Overflow: reload and request the timer interrupt
                        timer_next             = timer_reload_reg;
                        flags_next[FLAG_TIMER] = 1'b1;
                    end
                    else
                        timer_next = timer_reg + 8'd1;
                end
            end

            if (dpast)
            begin
                divider_mark_next = in_count_reg;
                divider_next      = divider_reg + 8'd1;
            end

            coin_next = 1'b0;
            if (lpast)
            begin
                line_mark_next = in_count_reg;
                line_next      = (line_reg == LAST_LINE) ? 8'd0 : line_reg + 8'd1;
                elapsed        = '0;
                render         = (line_next < VBLANK_LINE);
                if (line_next == line_compare_reg)
                begin
                    coin_next = 1'b1;
                    if (stat_enables_reg[3])
                        flags_next[FLAG_STAT] = 1'b1;
                end
                if (line_next == VBLANK_LINE)
                begin
                    flags_next[FLAG_VBLANK] = 1'b1;
                    if (stat_enables_reg[1] && mode_next != MODE_VBLANK)
                        flags_next[FLAG_STAT] = 1'b1;
                    mode_next = MODE_VBLANK;
                end
            end

            // Mode within a visible line; vblank lines keep the mode
            if (line_next < VBLANK_LINE)
            begin
                if (elapsed < COUNT_WIDTH'(OAM_END))
                begin
                    if (stat_enables_reg[2] && mode_next != MODE_OAM)
                        flags_next[FLAG_STAT] = 1'b1;
                    mode_next = MODE_OAM;
                end
                else if (elapsed < COUNT_WIDTH'(TRANSFER_END))
                    mode_next = MODE_TRANSFER;
                else
                begin
                    if (stat_enables_reg[0] && mode_next != MODE_HBLANK)
                        flags_next[FLAG_STAT] = 1'b1;
                    mode_next = MODE_HBLANK;
                end
            end
        end
        else if (in_me_reg)
        begin
            // Fixed priority: vblank, stat, timer; serial and joypad only clear master
            if (active[FLAG_VBLANK])
            begin
                flags_next[FLAG_VBLANK] = 1'b0;
                vec = VEC_VBLANK;
                clr = 1'b1;
            end
            else if (active[FLAG_STAT])
            begin
                flags_next[FLAG_STAT] = 1'b0;
                vec = VEC_STAT;
                clr = 1'b1;
            end
            else if (active[FLAG_TIMER])
            begin
                flags_next[FLAG_TIMER] = 1'b0;
                vec = VEC_TIMER;
                clr = 1'b1;
            end
            else if (active[FLAG_SERIAL] || active[FLAG_JOYPAD])
                clr = 1'b1;
        end

        out_data_next = {7'd0, render, flags_next, coin_next, mode_next,
                         line_next, divider_next, timer_next, clr, vec};
    end

    // State and result update on each processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_mark_reg   <= '0;
            divider_mark_reg <= '0;
            line_mark_reg    <= '0;
            timer_reg        <= '0;
            divider_reg      <= '0;
            line_reg         <= '0;
            mode_reg         <= MODE_HBLANK;
            coin_reg         <= 1'b0;
            flags_reg        <= '0;
        end
        else if (fire)
        begin
            timer_mark_reg   <= timer_mark_next;
            divider_mark_reg <= divider_mark_next;
            line_mark_reg    <= line_mark_next;
            timer_reg        <= timer_next;
            divider_reg      <= divider_next;
            line_reg         <= line_next;
            mode_reg         <= mode_next;
            coin_reg         <= coin_next;
            flags_reg        <= flags_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_data_reg <= out_data_next;
    end

endmodule

// ----- design/tlcd_checker.sv -----
// Port-level checker for the timer / LCD line / interrupt unit, with its bind.
// Depends on tlcd_pkg and the top level timer_lcd_interrupt_unit.
module tlcd_checker
    import tlcd_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Line number stays within the frame
    a_line: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:24] <= LAST_LINE)
        else $error("line number out of range");

    // Only known start addresses leave the block
    a_vec: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[6:0] == VEC_NONE || m_tdata[6:0] == VEC_VBLANK ||
                      m_tdata[6:0] == VEC_STAT || m_tdata[6:0] == VEC_TIMER))
        else $error("unknown vector");

    // A dispatched vector always clears master enable
    a_clr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[6:0] != VEC_NONE |-> m_tdata[7])
        else $error("vector without master clear");

    // A render flag comes from an update onto a visible line, never a dispatch
    a_render: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[40] |->
            m_tdata[31:24] < VBLANK_LINE && m_tdata[6:0] == VEC_NONE && !m_tdata[7])
        else $error("render flag on wrong item");

endmodule

bind timer_lcd_interrupt_unit tlcd_checker u_tlcd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
